// ===== sv/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared constants and codes of the weighted random selector.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int W_W     = 32;
    localparam int T_W     = 40;
    localparam int F_W     = 16;
    localparam int Q_W     = 17;
    localparam int TGT_W   = T_W + F_W;

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_PICK = 2'd1;
    localparam logic [1:0] REQ_NORM = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_ZERO  = 2'd2;

endpackage

// ===== sv/weighted_random_selector.sv =====
// ----------------------------------------------------------------------------
// weighted_random_selector
// Roulette-wheel selection over a table of Q16.16 weights held in one RAM.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tuser: req_type; tdata: entry_index, weight_delta,
//                       renorm, random_fraction
//  m_axis    out        tuser: status; tdata: picked_index, entry_weight,
//                       total_weight
//
//  Add reads the entry and writes it back; pick scans the table with one RAM
//  read per cycle; normalize runs the entries one at a time through the serial
//  divider. An unknown request goes straight to the finish state.
//  Reset clears the presence bits and the total; the RAM needs no clearing.
//  A result waits in the output register while m_axis_tready is low; the
//  next request is taken meanwhile and holds in its final state until then.
// ----------------------------------------------------------------------------
module weighted_random_selector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[7:0], weight_delta[39:8], renorm[40],
    // random_fraction[56:41]
    input  logic [63:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // picked_index[7:0], entry_weight[39:8], total_weight[79:40]
    output logic [79:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);
    import wrs_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADD_RD    = 4'd1;
    localparam logic [3:0] S_ADD_WR    = 4'd2;
    localparam logic [3:0] S_NRM_CHK   = 4'd3;
    localparam logic [3:0] S_NRM_RD    = 4'd4;
    localparam logic [3:0] S_NRM_WAIT  = 4'd5;
    localparam logic [3:0] S_NRM_DIV   = 4'd6;
    localparam logic [3:0] S_PICK_MUL  = 4'd7;
    localparam logic [3:0] S_PICK_SCAN = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        req_reg, req_next;
    logic [7:0]        idx_reg, idx_next;
    logic [W_W-1:0]    delta_reg, delta_next;
    logic              norm_reg, norm_next;
    logic [F_W-1:0]    frac_reg, frac_next;
    logic [T_W-1:0]    total_reg, total_next;
    logic [T_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              scan_vld_reg, scan_vld_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [TGT_W-1:0]  target_reg, target_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        pick_reg, pick_next;
    logic [W_W-1:0]    eweight_reg, eweight_next;

    logic              out_vld_reg, out_vld_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [7:0]        out_pick_reg, out_pick_next;
    logic [W_W-1:0]    out_eweight_reg, out_eweight_next;
    logic [T_W-1:0]    out_total_reg, out_total_next;

    logic [W_W-1:0]    mem [ENTRIES];
    logic [ENTRIES-1:0] present_reg, present_next;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [W_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [W_W-1:0]    rd_q;
    logic              rd_pres_q;
    logic [W_W-1:0]    rd_w;

    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_q;

    logic [IDX_W-1:0]  idx_addr;
    logic [IDX_W-1:0]  cur_idx;
    logic [W_W+1:0]    add_sum;
    logic [W_W-1:0]    add_new;
    logic [T_W-1:0]    acc_add;
    logic [T_W-1:0]    q_ext;
    logic              out_free;

    assign idx_addr = IDX_W'(idx_reg);
    assign cur_idx  = addr_reg[IDX_W-1:0];
    assign rd_w     = rd_pres_q ? rd_q : '0;
    assign add_sum  = {2'b00, rd_w} + {{2{delta_reg[W_W-1]}}, delta_reg};
    assign add_new  = add_sum[W_W+1] ? '0 : (add_sum[W_W] ? '1 : add_sum[W_W-1:0]);
    assign acc_add  = sum_reg + T_W'(rd_w);
    assign q_ext    = T_W'(div_q);
    assign out_free = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q      <= mem[mem_raddr];
        rd_pres_q <= present_reg[mem_raddr];
    end

    wrs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_w),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        delta_next    = delta_reg;
        norm_next     = norm_reg;
        frac_next     = frac_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        addr_next     = addr_reg;
        scan_vld_next = 1'b0;
        scan_idx_next = cur_idx;
        target_next   = target_reg;
        status_next   = status_reg;
        pick_next     = pick_reg;
        eweight_next  = eweight_reg;
        present_next  = present_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_idx;
        mem_wdata     = '0;
        mem_raddr     = cur_idx;
        div_start     = 1'b0;

        out_vld_next     = out_vld_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_pick_next    = out_pick_reg;
        out_eweight_next = out_eweight_reg;
        out_total_next   = out_total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next     = s_axis_tuser;
                    idx_next     = s_axis_tdata[7:0];
                    delta_next   = s_axis_tdata[39:8];
                    norm_next    = s_axis_tdata[40];
                    frac_next    = s_axis_tdata[56:41];
                    status_next  = STAT_EMPTY;
                    pick_next    = '0;
                    eweight_next = '0;
                    case (s_axis_tuser)
                        REQ_ADD:
                        begin
                            if (32'(s_axis_tdata[7:0]) < ENTRIES)
                            begin
                                state_next = S_ADD_RD;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        REQ_PICK: state_next = S_PICK_MUL;
                        REQ_NORM: state_next = S_NRM_CHK;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_ADD_RD:
            begin
                mem_raddr  = idx_addr;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                mem_we                 = 1'b1;
                mem_waddr              = idx_addr;
                mem_wdata              = add_new;
                present_next[idx_addr] = 1'b1;
                total_next   = total_reg - T_W'(rd_w) + T_W'(add_new);
                eweight_next = add_new;
                status_next  = STAT_OK;
                state_next   = norm_reg ? S_NRM_CHK : S_FINISH;
            end
            S_NRM_CHK:
            begin
                addr_next = '0;
                sum_next  = '0;
                if (total_reg == '0)
                begin
                    status_next = STAT_ZERO;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_NRM_RD;
                end
            end
            S_NRM_RD:
            begin
                state_next = S_NRM_WAIT;
            end
            S_NRM_WAIT:
            begin
                div_start  = 1'b1;
                state_next = S_NRM_DIV;
            end
            S_NRM_DIV:
            begin
                if (div_done)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = W_W'(div_q);
                    sum_next  = sum_reg + q_ext;
                    if (req_reg == REQ_ADD && cur_idx == idx_addr)
                    begin
                        eweight_next = W_W'(div_q);
                    end
                    if (cur_idx == IDX_W'(ENTRIES - 1))
                    begin
                        total_next  = sum_reg + q_ext;
                        status_next = STAT_OK;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        addr_next  = addr_reg + CNT_W'(1);
                        state_next = S_NRM_RD;
                    end
                end
            end
            S_PICK_MUL:
            begin
                target_next = TGT_W'(frac_reg) * TGT_W'(total_reg);
                addr_next   = '0;
                sum_next    = '0;
                state_next  = S_PICK_SCAN;
            end
            S_PICK_SCAN:
            begin
                if (addr_reg < CNT_W'(ENTRIES))
                begin
                    scan_vld_next = 1'b1;
                    addr_next     = addr_reg + CNT_W'(1);
                end
                if (scan_vld_reg && rd_pres_q)
                begin
                    sum_next = acc_add;
                end
                if (scan_vld_reg && rd_pres_q && {acc_add, 16'h0000} >= target_reg)
                begin
                    status_next  = STAT_OK;
                    pick_next    = 8'(scan_idx_reg);
                    eweight_next = rd_q;
                    state_next   = S_FINISH;
                end
                else if (scan_vld_reg && scan_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next     = 1'b1;
                    out_status_next  = status_reg;
                    out_pick_next    = pick_reg;
                    out_eweight_next = eweight_reg;
                    out_total_next   = total_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            present_reg  <= '0;
            out_vld_reg  <= 1'b0;
            scan_vld_reg <= 1'b0;
            addr_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            present_reg  <= present_next;
            out_vld_reg  <= out_vld_next;
            scan_vld_reg <= scan_vld_next;
            addr_reg     <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        idx_reg         <= idx_next;
        delta_reg       <= delta_next;
        norm_reg        <= norm_next;
        frac_reg        <= frac_next;
        sum_reg         <= sum_next;
        scan_idx_reg    <= scan_idx_next;
        target_reg      <= target_next;
        status_reg      <= status_next;
        pick_reg        <= pick_next;
        eweight_reg     <= eweight_next;
        out_status_reg  <= out_status_next;
        out_pick_reg    <= out_pick_next;
        out_eweight_reg <= out_eweight_next;
        out_total_reg   <= out_total_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_total_reg, out_eweight_reg, out_pick_reg};
    assign m_axis_tuser  = out_status_reg;

    a_mem_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_ADD_WR || state_reg == S_NRM_DIV))
        else $error("RAM write outside add or normalize write-back");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_NRM_DIV))
        else $error("divider finished outside normalize");

    a_pick_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK_SCAN) |=> $stable(total_reg))
        else $error("total changed during pick scan");

endmodule

// ===== sv/wrs_div.sv =====
// ----------------------------------------------------------------------------
// wrs_div
// Restoring divider: (weight * 65536) / total, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrs_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [wrs_pkg::W_W-1:0]  dividend,
    input  logic [wrs_pkg::T_W-1:0]  divisor,
    output logic                     done,
    output logic [wrs_pkg::Q_W-1:0]  quotient
);
    import wrs_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [T_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic             lsb_reg, lsb_next;
    logic [T_W:0]     shifted;
    logic [T_W:0]     diff;
    logic             in_bit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        lsb_next  = lsb_reg;
        in_bit    = (cnt_reg == 5'(Q_W - 1)) ? lsb_reg : 1'b0;
        shifted   = {rem_reg, in_bit};
        diff      = shifted - {1'b0, divisor};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(Q_W - 1);
            rem_next  = T_W'(dividend >> 1);
            lsb_next  = dividend[0];
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next  = diff[T_W-1:0];
                quot_next = {quot_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[T_W-1:0];
                quot_next = {quot_reg[Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        lsb_reg  <= lsb_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== bench/wrs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrs_checker
// Watches both stream channels of the weighted random selector, keeps its own
// copy of the weight table and presence bits, works out the total and the
// outcome of every accepted request and compares each returned result with the
// oldest outstanding outcome, field by field.
// ----------------------------------------------------------------------------
module wrs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          errors,
    output int          pending
);
    import wrs_pkg::*;

    localparam logic [63:0] TOTAL_SAT  = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] WEIGHT_SAT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]   status;
        logic [7:0]   picked;
        logic [W_W-1:0] weight;
        logic [T_W-1:0] total;
    } outcome_t;

    logic [W_W-1:0] weights [ENTRIES];
    logic           present [ENTRIES];
    outcome_t       outcomes [$];

    function automatic logic [63:0] weight_sum();
        logic [63:0] s;
        s = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            s = s + weights[i];
            if (s > TOTAL_SAT)
                s = TOTAL_SAT;
        end
        return s;
    endfunction

    function automatic logic [1:0] rescale_weights();
        logic [63:0] t;
        t = weight_sum();
        if (t == 0)
            return STAT_ZERO;
        for (int i = 0; i < ENTRIES; i++)
            weights[i] = W_W'({32'd0, weights[i], 16'd0} / {24'd0, t[39:0]});
        return STAT_OK;
    endfunction

    function automatic outcome_t serve_request(logic [1:0] req, logic [63:0] data);
        outcome_t          o;
        logic [7:0]        idx;
        logic signed [63:0] nw;
        logic [63:0]       t;
        logic [63:0]       target;
        logic [63:0]       acc;
        idx = data[7:0];
        o = '0;
        o.status = STAT_EMPTY;
        if (req == REQ_ADD)
        begin
            nw = $signed({32'd0, weights[idx]}) + $signed({{32{data[39]}}, data[39:8]});
            if (nw < 0)
                nw = 0;
            if (nw > $signed(WEIGHT_SAT))
                nw = $signed(WEIGHT_SAT);
            weights[idx] = nw[31:0];
            present[idx] = 1'b1;
            o.status = STAT_OK;
            if (data[40])
                o.status = rescale_weights();
            o.weight = weights[idx];
        end
        else if (req == REQ_PICK)
        begin
            t = weight_sum();
            target = {48'd0, data[56:41]} * t;
            acc = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (present[i])
                begin
                    acc = acc + weights[i];
                    if (acc > TOTAL_SAT)
                        acc = TOTAL_SAT;
                    if ((acc << 16) >= target)
                    begin
                        o.status = STAT_OK;
                        o.picked = i[7:0];
                        o.weight = weights[i];
                        break;
                    end
                end
            end
        end
        else if (req == REQ_NORM)
        begin
            o.status = rescale_weights();
        end
        t = weight_sum();
        o.total = t[39:0];
        return o;
    endfunction

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            errors = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                weights[i] = '0;
                present[i] = 1'b0;
            end
            outcomes.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                       m_axis_tdata[79:40]};
                if (outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = outcomes.pop_front();
                    if (got.status != want.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, want.status,
                                 got.status);
                        errors++;
                    end
                    if (got.picked != want.picked)
                    begin
                        $display("%0t: picked_index exp %0d got %0d", $time, want.picked,
                                 got.picked);
                        errors++;
                    end
                    if (got.weight != want.weight)
                    begin
                        $display("%0t: entry_weight exp %h got %h", $time, want.weight,
                                 got.weight);
                        errors++;
                    end
                    if (got.total != want.total)
                    begin
                        $display("%0t: total_weight exp %h got %h", $time, want.total,
                                 got.total);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outcomes.push_back(serve_request(s_axis_tuser, s_axis_tdata));
        end
        pending = outcomes.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives add, pick, normalize and unknown requests into the weighted random
// selector under changing idle and stall patterns, a long output hold-off and
// a full drain, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import wrs_pkg::*;

    localparam int QUIET_LIMIT = 60000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;
    logic hold_req;
    logic hold_used;

    weighted_random_selector u_dut (.*);

    wrs_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_used     <= 1'b0;
        end
        else if (hold_req && !hold_used)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_used     <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("weighted_random_selector: mismatch");
            $finish;
        end
    end

    task automatic issue(logic [1:0] req, logic [7:0] idx, logic [31:0] delta,
                         logic norm, logic [15:0] frac);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, frac, norm, delta, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic random_request();
        int          r;
        logic [31:0] delta;
        logic [7:0]  idx;
        r = $urandom_range(99);
        idx = ($urandom_range(3) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
        case ($urandom_range(3))
            0: delta = $urandom;
            1: delta = -32'($urandom_range(200000));
            default: delta = $urandom_range(400000);
        endcase
        if (r < 60)
            issue(REQ_ADD, idx, delta, $urandom_range(99) < 3, 16'($urandom));
        else if (r < 93)
            issue(REQ_PICK, 8'($urandom), $urandom, 1'($urandom), 16'($urandom));
        else if (r < 97)
            issue(REQ_NORM, 8'($urandom), $urandom, 1'($urandom), 16'($urandom));
        else
            issue(REQ_UNKNOWN, 8'($urandom), $urandom, 1'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(REQ_PICK, 8'd0, 32'd0, 1'b0, 16'd100);
        issue(REQ_NORM, 8'd0, 32'd0, 1'b0, 16'd0);
        issue(REQ_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        issue(REQ_ADD, 8'd7, 32'd0, 1'b1, 16'd0);
        issue(REQ_PICK, 8'd0, 32'd0, 1'b0, 16'd12345);
        issue(REQ_ADD, 8'd0, 32'h7FFF_FFFF, 1'b0, 16'd0);
        issue(REQ_ADD, 8'd255, 32'h7FFF_FFFF, 1'b0, 16'hFFFF);
        issue(REQ_ADD, 8'd255, 32'h7FFF_FFFF, 1'b0, 16'd0);
        issue(REQ_ADD, 8'd255, 32'h7FFF_FFFF, 1'b0, 16'd0);
        issue(REQ_ADD, 8'd5, 32'h8000_0000, 1'b0, 16'd0);
        issue(REQ_PICK, 8'd0, 32'd0, 1'b0, 16'd0);
        issue(REQ_PICK, 8'd0, 32'd0, 1'b0, 16'hFFFF);
        issue(REQ_PICK, 8'd0, 32'd0, 1'b0, 16'h8000);
        issue(REQ_NORM, 8'd0, 32'd0, 1'b0, 16'd0);
        issue(REQ_ADD, 8'd3, 32'h0001_0000, 1'b1, 16'd0);
        issue(REQ_ADD, 8'd0, 32'h8000_0000, 1'b0, 16'd0);
        issue(REQ_PICK, 8'd0, 32'd0, 1'b0, 16'h4000);
        issue(REQ_UNKNOWN, 8'd0, 32'd0, 1'b0, 16'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? 77 : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? 77 : 0;
            if (phase == 3)
            begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
            if (phase == 0)
                hold_req = 1'b1;
            if (phase == 2)
                wait (pending == 0);
            for (int n = 0; n < 210; n++)
                random_request();
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("weighted_random_selector: match");
        else
            $display("weighted_random_selector: mismatch");
        $finish;
    end

endmodule
